### sv/hrle_pkg.sv
// Shared types, constants and helper functions for the hex run-length row decoder.
package hrle_pkg;

  // Where the decoder stands between code byte and count bytes.
  typedef enum logic [1:0] {
    PH_CODE   = 2'd0,
    PH_COUNT1 = 2'd1,
    PH_COUNT2 = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  // Configuration register indexes.
  localparam logic REG_MONO_OUTPUT = 1'b0;
  localparam logic REG_ROW_WIDTH   = 1'b1;

  // Character codes that bound the text classes.
  localparam logic [7:0] CHR_FIRST_PRINT = 8'h20;
  localparam logic [7:0] CHR_DEL         = 8'h7F;

  // Pair and repeat used for a broken code byte and for line padding.
  localparam logic [5:0] PAIR_ALL_SEVEN = 6'h3F;
  localparam logic [9:0] RPT_BAD_CODE   = 10'd3;

  // Width of the row counters and the widest row the ports can describe.
  localparam int unsigned ColW     = 11;
  localparam int unsigned WidthCap = 2047;

  // Palette of the eight pixel indices, RGB 8:8:8.
  localparam logic [23:0] Palette [8] = '{
    24'h000000, 24'hFFFFC8, 24'hFF8282, 24'h00FF00,
    24'hFF00FF, 24'h00FFFF, 24'h8C8C8C, 24'hFF0000
  };

  // One run record as it waits for the output side.
  typedef struct packed {
    logic [5:0]      pair;
    logic [ColW-1:0] count;
    logic [9:0]      start;
    logic            bad;
    logic            ovf;
    logic            pad;
    logic            done;
  } rec_t;

  // Returns {bad, value} for one hex character.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = {1'b1, 4'h0};
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Colour of one pixel index: palette entry or a mono bit.
  function automatic logic [23:0] colour_of(input logic [2:0] idx, input logic mono);
    logic [23:0] r;
    r = Palette[idx];
    if (mono) begin
      r = {23'd0, (idx != 3'd0)};
    end
    return r;
  endfunction

endpackage

### sv/hex_rle_pixel_row_decoder.sv
// Top level of the hex run-length pixel row decoder.
// Takes one character word per cycle while in_ready_o is high and turns hex code bytes
// into run records (pair, count, start column, flags), clipped at the row width; a line
// end closes a non-empty row with a padding record. Each accepted word produces zero, one
// or two records; only a line end that interrupts an unfinished code or count produces
// two. The word is decoded combinationally against the row state and the records are
// written into a four-word output queue, which registers the results and decouples the
// two sides. in_ready_o is high while the queue holds at most two records, so words
// stream back to back at one per cycle whenever the consumer keeps up; a two-record line
// end is handed out as two output words. Configuration writes take effect on the next
// cycle and are expected only while the block is idle.
module hex_rle_pixel_row_decoder #(
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  // Character input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_line_i,
  // Record output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  first_pixel_o,
  output logic [2:0]  second_pixel_o,
  output logic [23:0] first_colour_o,
  output logic [23:0] second_colour_o,
  output logic [10:0] pixel_count_o,
  output logic [9:0]  start_column_o,
  output logic        bad_input_o,
  output logic        overflowed_o,
  output logic        padding_run_o,
  output logic        row_done_o
);
  import hrle_pkg::*;

  localparam logic [ColW-1:0] MaxW = ColW'((MAX_COLS > WidthCap) ? WidthCap : MAX_COLS);

  // Configuration registers.
  logic            mono_q;
  logic [ColW-1:0] row_width_q;

  // Row decode state.
  logic [3:0]      hn_q, hn_d;
  logic            np_q, np_d;
  logic            hn_bad_q, hn_bad_d;
  phase_e          phase_q, phase_d;
  logic [5:0]      saved_q, saved_d;
  logic [1:0]      ch_q, ch_d;
  logic [ColW-1:0] col_q, col_d;
  logic            ovf_q, ovf_d;
  logic            lhc_q, lhc_d;

  // Decode signals.
  logic            in_fire, is_ctrl, step, pair_done, eol_fire;
  logic [4:0]      nib_res;
  logic            byte_bad;
  logic [7:0]      code_byte;
  logic            run_emit, pad_emit, run_bad;
  logic [5:0]      run_pair;
  logic [9:0]      run_rpt;
  logic [ColW-1:0] eff_w, left, want, run_n, pad_left, pad_start;
  logic            clip;
  rec_t            run_rec, pad_rec, push_a, head;
  logic [1:0]      push_n;
  logic            room_two, pop;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q      <= 1'b0;
      row_width_q <= 11'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MONO_OUTPUT: mono_q      <= cfg_data_i[0];
        REG_ROW_WIDTH:   row_width_q <= cfg_data_i;
        default:         mono_q      <= mono_q;
      endcase
    end
  end

  // Character classification and byte assembly.
  assign in_ready_o = room_two;
  assign in_fire    = in_valid_i && room_two;
  assign eol_fire   = in_fire && end_of_line_i;
  assign is_ctrl    = (char_code_i < CHR_FIRST_PRINT) || (char_code_i == CHR_DEL);
  assign step       = in_fire && !end_of_line_i && !is_ctrl && !ovf_q;
  assign pair_done  = step && np_q;
  assign nib_res    = hex_nibble(char_code_i);
  assign byte_bad   = hn_bad_q || nib_res[4];
  assign code_byte  = byte_bad ? 8'hFF : {hn_q, nib_res[3:0]};

  // Phase sequencing and run requests.
  always_comb begin
    phase_d  = phase_q;
    saved_d  = saved_q;
    ch_d     = ch_q;
    run_emit = 1'b0;
    run_pair = saved_q;
    run_rpt  = 10'd0;
    run_bad  = 1'b0;
    if (eol_fire) begin
      if (lhc_q && !ovf_q && (np_q || phase_q != PH_CODE)) begin
        run_emit = 1'b1;
        run_bad  = 1'b1;
        if (phase_q == PH_CODE) begin
          run_pair = PAIR_ALL_SEVEN;
          run_rpt  = RPT_BAD_CODE;
        end
      end
      phase_d = PH_CODE;
      saved_d = '0;
      ch_d    = '0;
    end else if (pair_done) begin
      unique case (phase_q)
        PH_CODE: begin
          if (code_byte[7:6] != 2'd0) begin
            run_emit = 1'b1;
            run_pair = code_byte[5:0];
            run_rpt  = {8'd0, code_byte[7:6]};
            run_bad  = byte_bad;
          end else begin
            saved_d = code_byte[5:0];
            phase_d = PH_COUNT1;
          end
        end
        PH_COUNT1: begin
          if (byte_bad) begin
            phase_d = PH_SKIP;
          end else if (code_byte >= 8'd4) begin
            run_emit = 1'b1;
            run_rpt  = {2'd0, code_byte};
            phase_d  = PH_CODE;
          end else begin
            ch_d    = code_byte[1:0];
            phase_d = PH_COUNT2;
          end
        end
        PH_COUNT2: begin
          run_emit = 1'b1;
          run_bad  = byte_bad;
          run_rpt  = byte_bad ? 10'd0 : {ch_q, code_byte};
          phase_d  = PH_CODE;
        end
        PH_SKIP: begin
          run_emit = 1'b1;
          run_bad  = 1'b1;
          phase_d  = PH_CODE;
        end
        default: phase_d = PH_CODE;
      endcase
    end
  end

  // Nibble pairing and line bookkeeping.
  always_comb begin
    hn_d     = hn_q;
    np_d     = np_q;
    hn_bad_d = hn_bad_q;
    col_d    = col_q;
    ovf_d    = ovf_q;
    lhc_d    = lhc_q;
    if (eol_fire) begin
      hn_d     = '0;
      np_d     = 1'b0;
      hn_bad_d = 1'b0;
      col_d    = '0;
      ovf_d    = 1'b0;
      lhc_d    = 1'b0;
    end else begin
      if (in_fire && !is_ctrl) begin
        lhc_d = 1'b1;
      end
      if (pair_done) begin
        hn_d     = '0;
        np_d     = 1'b0;
        hn_bad_d = 1'b0;
      end else if (step) begin
        hn_d     = nib_res[3:0];
        hn_bad_d = nib_res[4];
        np_d     = 1'b1;
      end
      if (run_emit) begin
        col_d = col_q + run_n;
        if (clip) begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  // Clipping against the space left in the row.
  always_comb begin
    eff_w     = (row_width_q > MaxW) ? MaxW : row_width_q;
    left      = (col_q < eff_w) ? (eff_w - col_q) : '0;
    want      = {run_rpt, 1'b0};
    clip      = want > left;
    run_n     = clip ? left : want;
    pad_left  = run_emit ? (left - run_n) : left;
    pad_start = run_emit ? (col_q + run_n) : col_q;
  end

  // Record assembly.
  always_comb begin
    run_rec       = '0;
    run_rec.pair  = run_pair;
    run_rec.count = run_n;
    run_rec.start = col_q[9:0];
    run_rec.bad   = run_bad;
    run_rec.ovf   = clip;
    pad_rec       = '0;
    pad_rec.pair  = PAIR_ALL_SEVEN;
    pad_rec.count = pad_left;
    pad_rec.start = pad_start[9:0];
    pad_rec.pad   = 1'b1;
    pad_rec.done  = 1'b1;
    pad_emit      = eol_fire && lhc_q;
    push_a        = run_emit ? run_rec : pad_rec;
    push_n        = {1'b0, run_emit} + {1'b0, pad_emit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hn_q     <= '0;
      np_q     <= 1'b0;
      hn_bad_q <= 1'b0;
      phase_q  <= PH_CODE;
      saved_q  <= '0;
      ch_q     <= '0;
      col_q    <= '0;
      ovf_q    <= 1'b0;
      lhc_q    <= 1'b0;
    end else begin
      hn_q     <= hn_d;
      np_q     <= np_d;
      hn_bad_q <= hn_bad_d;
      phase_q  <= phase_d;
      saved_q  <= saved_d;
      ch_q     <= ch_d;
      col_q    <= col_d;
      ovf_q    <= ovf_d;
      lhc_q    <= lhc_d;
    end
  end

  // Output queue.
  assign pop = out_valid_o && out_ready_i;

  hrle_rec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_a_i    (push_a),
    .push_b_i    (pad_rec),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (out_valid_o),
    .room_two_o  (room_two)
  );

  // Output word, colours looked up from the stored indices.
  assign first_pixel_o   = head.pair[2:0];
  assign second_pixel_o  = head.pair[5:3];
  assign first_colour_o  = colour_of(head.pair[2:0], mono_q);
  assign second_colour_o = colour_of(head.pair[5:3], mono_q);
  assign pixel_count_o   = head.count;
  assign start_column_o  = head.start;
  assign bad_input_o     = head.bad;
  assign overflowed_o    = head.ovf;
  assign padding_run_o   = head.pad;
  assign row_done_o      = head.done;

endmodule

### sv/hrle_rec_queue.sv
// Four-entry record queue that takes up to two records per cycle and gives one.
module hrle_rec_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  hrle_pkg::rec_t push_a_i,
  input  hrle_pkg::rec_t push_b_i,
  input  logic          pop_i,
  output hrle_pkg::rec_t head_o,
  output logic          not_empty_o,
  output logic          room_two_o
);
  import hrle_pkg::*;

  localparam int unsigned Depth = 4;

  rec_t       mem_q [Depth];
  logic [1:0] head_q, head_d;
  logic [1:0] tail_q, tail_d;
  logic [2:0] count_q, count_d;
  logic [1:0] tail_next;

  assign tail_next   = tail_q + 2'd1;
  assign head_o      = mem_q[head_q];
  assign not_empty_o = (count_q != 3'd0);
  assign room_two_o  = (count_q <= 3'd2);

  // Pointer and fill bookkeeping.
  always_comb begin
    head_d  = head_q + {1'b0, pop_i};
    tail_d  = tail_q + push_n_i;
    count_d = count_q + {1'b0, push_n_i} - {2'b00, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Entry storage; the second record lands one slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[tail_q] <= push_a_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[tail_next] <= push_b_i;
    end
  end

endmodule

### sv/hrle_checker.sv
// Port-level checker for the hex run-length row decoder, bound to the top level.
module hrle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  first_pixel_o,
  input logic [2:0]  second_pixel_o,
  input logic [23:0] first_colour_o,
  input logic [10:0] pixel_count_o,
  input logic [9:0]  start_column_o,
  input logic        bad_input_o,
  input logic        overflowed_o,
  input logic        padding_run_o,
  input logic        row_done_o
);

  // A stalled word keeps its place in the row.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(start_column_o)
      && $stable(pixel_count_o))
    else $error("stalled output word changed");

  // Padding closes the row and is never flagged.
  a_pad_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && padding_run_o |-> row_done_o && !overflowed_o && !bad_input_o)
    else $error("padding word carries wrong flags");

  // Only padding ends a row, and padding uses index seven.
  a_done_is_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_done_o |-> padding_run_o && first_pixel_o == 3'd7
      && second_pixel_o == 3'd7)
    else $error("row end word is not a padding run");

  // Index zero is black in both colour modes.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_pixel_o == 3'd0 |-> first_colour_o == 24'd0)
    else $error("index zero gave a nonzero colour");

endmodule

bind hex_rle_pixel_row_decoder hrle_checker u_hrle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .first_pixel_o  (first_pixel_o),
  .second_pixel_o (second_pixel_o),
  .first_colour_o (first_colour_o),
  .pixel_count_o  (pixel_count_o),
  .start_column_o (start_column_o),
  .bad_input_o    (bad_input_o),
  .overflowed_o   (overflowed_o),
  .padding_run_o  (padding_run_o),
  .row_done_o     (row_done_o)
);
